// ===== sv/button_debounce_gesture_fsm_defines.svh =====
// Assertion macros for the button debounce and gesture block.
// Used by the top level only; the checks compile away when SYNTH is defined.
`ifndef BUTTON_DEBOUNCE_GESTURE_FSM_DEFINES_SVH
`define BUTTON_DEBOUNCE_GESTURE_FSM_DEFINES_SVH

`ifndef SYNTH

// Consequent must hold in the same cycle as the antecedent.
`define BDG_ASSERT_SAME(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdg check failed");

// Consequent must hold in the cycle after the antecedent.
`define BDG_ASSERT_NEXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdg check failed");

`else

`define BDG_ASSERT_SAME(name, clk, rst, ante, cons)
`define BDG_ASSERT_NEXT(name, clk, rst, ante, cons)

`endif

`endif

// ===== sv/bdg_pkg.sv =====
// Shared types and constants for the button debounce and gesture block.
// No dependencies; used by the stream interfaces and the top level.
`timescale 1ns / 1ps
`default_nettype none

package bdg_pkg;

  // Gesture state codes, also the code carried on the result channel.
  typedef enum logic [2:0] {
    G_IDLE     = 3'd0,
    G_UP       = 3'd1,
    G_DOWN     = 3'd2,
    G_MEM_UP   = 3'd3,
    G_MEM_DOWN = 3'd4,
    G_SAVE     = 3'd5
  } gesture_t;

  // Register map: the index is byte address bit 2.
  localparam logic REG_DEBOUNCE_LIMIT  = 1'b0;
  localparam logic REG_SAVE_HOLD_LIMIT = 1'b1;

  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;

  localparam logic [7:0] DEBOUNCE_LIMIT_RST  = 8'd200;
  localparam logic [7:0] SAVE_HOLD_LIMIT_RST = 8'd60;
  localparam logic [7:0] COUNT_MAX           = 8'hFF;

endpackage

`default_nettype wire

// ===== sv/bdg_if.sv =====
// Valid/ready stream interfaces for poll ticks and gesture results.
// Depends on bdg_pkg for the gesture code type.
`timescale 1ns / 1ps
`default_nettype none

// One beat is one poll tick with the raw active-low button levels.
interface bdg_tick_if;
  logic       valid;
  logic       ready;
  logic [1:0] buttons_raw;

  modport source (output valid, output buttons_raw, input ready);
  modport sink (input valid, input buttons_raw, output ready);
endinterface

// One beat is one new gesture code.
interface bdg_gesture_if import bdg_pkg::*;;
  logic     valid;
  logic     ready;
  gesture_t gesture;

  modport source (output valid, output gesture, input ready);
  modport sink (input valid, input gesture, output ready);
endinterface

`default_nettype wire

// ===== sv/button_debounce_gesture_fsm.sv =====
// A tick that changes the gesture has its code registered into the result buffer when it is accepted.
// Throughput: one tick per cycle; debounce, gesture step and state update all
// complete in the accept cycle, and a two-entry result buffer absorbs output stalls.
// Ticks stall only while both result buffer entries are occupied.
// Reset (synchronous, active high): limits return to 200 and 60, counters clear,
// stored levels read as both pressed, gesture is idle and the result buffer empties.
// Depends on bdg_pkg, bdg_if.sv and button_debounce_gesture_fsm_defines.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_gesture_fsm_defines.svh"

module button_debounce_gesture_fsm import bdg_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  bdg_tick_if.sink                   tick,
  bdg_gesture_if.source              result,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  // Configuration and state registers.
  logic [7:0] debounce_limit;
  logic [7:0] save_hold_limit;
  logic [7:0] stable_count, stable_count_next;
  logic [7:0] hold_count, hold_count_next;
  logic [1:0] last_raw, last_raw_next;
  gesture_t   gesture_state, gesture_state_next;

  // Result buffer: entry 0 is the head driven onto the result channel.
  logic [1:0] res_cnt, res_cnt_next;
  gesture_t   res_buf0, res_buf0_next;
  gesture_t   res_buf1, res_buf1_next;

  logic       accept;
  logic       pop;
  logic       up_pressed;
  logic       dn_pressed;
  logic [7:0] count_inc;
  logic       step;
  logic [7:0] hold_inc;
  gesture_t   step_state;
  logic [7:0] step_hold;
  logic       emit;
  logic [1:0] cnt_after_pop;
  gesture_t   buf0_after_pop;
  logic       cfg_write;

  assign accept = tick.valid && tick.ready;
  assign pop    = result.valid && result.ready;

  // APB register port: writes land on the access cycle, reads are combinational.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_limit  <= DEBOUNCE_LIMIT_RST;
      save_hold_limit <= SAVE_HOLD_LIMIT_RST;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_DEBOUNCE_LIMIT:  debounce_limit  <= pwdata[7:0];
        REG_SAVE_HOLD_LIMIT: save_hold_limit <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Misaligned reads return zero.
  always_comb begin
    prdata = '0;
    if (paddr[1:0] == 2'b00) begin
      unique case (paddr[2])
        REG_DEBOUNCE_LIMIT:  prdata = {{(APB_DATA_W-8){1'b0}}, debounce_limit};
        REG_SAVE_HOLD_LIMIT: prdata = {{(APB_DATA_W-8){1'b0}}, save_hold_limit};
        default:             prdata = '0;
      endcase
    end
  end

  // Debounce: a level change restarts the stable count, otherwise it saturates upward; a step restarts it.
  assign up_pressed = ~tick.buttons_raw[1];
  assign dn_pressed = ~tick.buttons_raw[0];
  assign count_inc  = (tick.buttons_raw != last_raw) ? 8'd0 :
                      (stable_count == COUNT_MAX)    ? stable_count :
                                                       stable_count + 8'd1;
  assign step       = (count_inc >= debounce_limit);

  always_comb begin
    stable_count_next = stable_count;
    last_raw_next     = last_raw;
    if (accept) begin
      last_raw_next     = tick.buttons_raw;
      stable_count_next = step ? 8'd0 : count_inc;
    end
  end

  // Gesture step: next state and hold counter for the current button levels.
  assign hold_inc = hold_count + 8'd1;

  always_comb begin
    step_state = G_IDLE;
    step_hold  = hold_count;
    unique case (gesture_state)
      G_SAVE: begin
        step_state = (up_pressed && dn_pressed) ? G_SAVE : G_IDLE;
      end
      G_UP: begin
        if (up_pressed && dn_pressed) step_state = G_MEM_UP;
        else if (up_pressed)          step_state = G_UP;
        else if (dn_pressed)          step_state = G_DOWN;
        else                          step_state = G_IDLE;
      end
      G_DOWN: begin
        if (up_pressed && dn_pressed) step_state = G_MEM_DOWN;
        else if (up_pressed)          step_state = G_UP;
        else if (dn_pressed)          step_state = G_DOWN;
        else                          step_state = G_IDLE;
      end
      G_MEM_UP: begin
        if (up_pressed)      step_state = G_MEM_UP;
        else if (dn_pressed) step_state = G_DOWN;
        else                 step_state = G_IDLE;
      end
      G_MEM_DOWN: begin
        if (dn_pressed)      step_state = G_MEM_DOWN;
        else if (up_pressed) step_state = G_UP;
        else                 step_state = G_IDLE;
      end
      default: begin
        // Idle, and the unused codes, which behave as idle.
        if (up_pressed && dn_pressed) begin
          if (hold_inc >= save_hold_limit) begin
            step_hold  = 8'd0;
            step_state = G_SAVE;
          end else begin
            step_hold  = hold_inc;
            step_state = G_IDLE;
          end
        end else if (up_pressed) begin
          step_state = G_UP;
        end else if (dn_pressed) begin
          step_state = G_DOWN;
        end else begin
          step_state = G_IDLE;
        end
      end
    endcase
  end

  // State update and result strobe: a code goes out only when the gesture changes.
  always_comb begin
    gesture_state_next = gesture_state;
    hold_count_next    = hold_count;
    emit               = 1'b0;
    if (accept && step) begin
      gesture_state_next = step_state;
      hold_count_next    = step_hold;
      emit               = (step_state != gesture_state);
    end
  end

  // Result buffer: pop the head first, then append the new code behind what remains.
  assign cnt_after_pop  = res_cnt - {1'b0, pop};
  assign buf0_after_pop = pop ? res_buf1 : res_buf0;

  always_comb begin
    res_cnt_next  = cnt_after_pop + {1'b0, emit};
    res_buf0_next = buf0_after_pop;
    res_buf1_next = res_buf1;
    if (emit && (cnt_after_pop == 2'd0)) res_buf0_next = step_state;
    if (emit && (cnt_after_pop == 2'd1)) res_buf1_next = step_state;
  end

  assign tick.ready     = (res_cnt != 2'd2);
  assign result.valid   = (res_cnt != 2'd0);
  assign result.gesture = res_buf0;

  always_ff @(posedge clk) begin
    if (rst) begin
      stable_count  <= 8'd0;
      hold_count    <= 8'd0;
      last_raw      <= 2'b00;
      gesture_state <= G_IDLE;
      res_cnt       <= 2'd0;
    end else begin
      stable_count  <= stable_count_next;
      hold_count    <= hold_count_next;
      last_raw      <= last_raw_next;
      gesture_state <= gesture_state_next;
      res_cnt       <= res_cnt_next;
    end
  end

  // Buffer payload needs no reset.
  always_ff @(posedge clk) begin
    res_buf0 <= res_buf0_next;
    res_buf1 <= res_buf1_next;
  end

  // Checks on the buffer occupancy and the gesture sequencing.
  `BDG_ASSERT_SAME(a_cnt_in_range, clk, rst, 1'b1, res_cnt != 2'd3)
  `BDG_ASSERT_SAME(a_no_push_when_full, clk, rst, emit, cnt_after_pop != 2'd2)
  `BDG_ASSERT_NEXT(a_emit_changes_state, clk, rst, emit, gesture_state != $past(gesture_state))
  `BDG_ASSERT_NEXT(a_save_only_from_idle, clk, rst,
                   gesture_state != G_SAVE && gesture_state != G_IDLE,
                   gesture_state != G_SAVE)

endmodule

`default_nettype wire
